/* rtl/pomodoro_phase_timer_top_defines.svh */
// assertion macros for the pomodoro phase timer checker
`ifndef POMODORO_PHASE_TIMER_TOP_DEFINES_SVH
`define POMODORO_PHASE_TIMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt assertion failed");

`endif

/* rtl/ppt_pkg.sv */
// shared types, codes and constants of the pomodoro phase timer
package ppt_pkg;

    localparam int STAT_COUNTER_WIDTH = 32;
    localparam int MAX_PHASE_MINUTES  = 120;
    localparam int BRK_HI             = (MAX_PHASE_MINUTES < 60) ? MAX_PHASE_MINUTES : 60;
    localparam int SECS_PER_MIN       = 60;
    localparam int PERMILLE           = 1000;
    localparam int ROUNDS_MAX         = 16;

    localparam int STAT_W     = STAT_COUNTER_WIDTH;
    localparam int OP_W       = 3;
    localparam int TICK_W     = 16;
    localparam int DAY_W      = 32;
    localparam int MODE_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int EV_W       = 2;
    localparam int SEC_W      = 13;
    localparam int PM_W       = 10;
    localparam int PROD_W     = SEC_W + PM_W;
    localparam int DIV_CNT_W  = $clog2(PM_W);
    localparam int FOCUS_W    = 7;
    localparam int BRK_W      = 6;
    localparam int ROUNDS_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 3'd0,
        MODE_FOCUS  = 3'd1,
        MODE_SHORT  = 3'd2,
        MODE_LONG   = 3'd3,
        MODE_PAUSED = 3'd4
    } mode_t;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_DAY    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO   = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_FOCUS = 2'd1;
    localparam logic [EV_W-1:0] EV_BREAK = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic prep;
        logic step;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } stat_t;

endpackage

/* rtl/pomodoro_phase_timer_top.sv */
// top level of the pomodoro phase timer: controller plus datapath
//
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall   | opcode, tick_seconds, day_stamp
// out     | out of    | out_valid / out_stall | accepted ... life_focus_minutes
// cfg     | into      | cfg_we (no wait)      | cfg_index, cfg_data
//
// an item passes from accept to the next accept through these steps: apply
// the command, find the shown phase and the scaled elapsed time, run the
// bit-serial permille divider one quotient bit a step, then load the result
// register
// reset is asynchronous, active low; config returns to its defaults and the
// timer to idle with all counters at zero
// in_stall is high from accept until the result is loaded; a stalled output
// holds the block in its last step, the result register keeps its item
module pomodoro_phase_timer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ppt_pkg::OP_W-1:0]            opcode,
    input  logic [ppt_pkg::TICK_W-1:0]          tick_seconds,
    input  logic [ppt_pkg::DAY_W-1:0]           day_stamp,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [ppt_pkg::EV_W-1:0]            phase_event,
    output logic [ppt_pkg::MODE_W-1:0]          run_state,
    output logic [ppt_pkg::PHASE_W-1:0]         shown_phase,
    output logic [ppt_pkg::SEC_W-1:0]           seconds_left,
    output logic [ppt_pkg::SEC_W-1:0]           phase_total_seconds,
    output logic [ppt_pkg::PM_W-1:0]            progress_permille,
    output logic [ppt_pkg::STAT_W-1:0]          run_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          day_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          day_focus_minutes,
    output logic [ppt_pkg::STAT_W-1:0]          life_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          life_focus_minutes,
    input  logic                                cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ppt_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: accept, prep, divide, load result
    ppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: config, timer state, counters, divider, result register
    ppt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .opcode              (opcode),
        .tick_seconds        (tick_seconds),
        .day_stamp           (day_stamp),
        .accepted            (accepted),
        .phase_event         (phase_event),
        .run_state           (run_state),
        .shown_phase         (shown_phase),
        .seconds_left        (seconds_left),
        .phase_total_seconds (phase_total_seconds),
        .progress_permille   (progress_permille),
        .run_focus_count     (run_focus_count),
        .day_focus_count     (day_focus_count),
        .day_focus_minutes   (day_focus_minutes),
        .life_focus_count    (life_focus_count),
        .life_focus_minutes  (life_focus_minutes)
    );

endmodule

/* rtl/ppt_ctrl.sv */
// sequencing state machine of the pomodoro phase timer
module ppt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output ppt_pkg::cmd_t cmd,
    input  ppt_pkg::stat_t stat
);
    import ppt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.exec = in_valid && !stall_reg;
        cmd.prep = (state_reg == S_PREP);
        cmd.step = (state_reg == S_DIV);
        cmd.load = (state_reg == S_HOLD) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stall_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.exec)
                    begin
                        state_reg <= S_PREP;
                        stall_reg <= 1'b1;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (stat.div_last)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= S_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = stall_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/ppt_dp.sv */
// timer state, counters, permille divider and result register
module ppt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppt_pkg::cmd_t                       cmd,
    output ppt_pkg::stat_t                      stat,
    input  logic                                cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [ppt_pkg::OP_W-1:0]            opcode,
    input  logic [ppt_pkg::TICK_W-1:0]          tick_seconds,
    input  logic [ppt_pkg::DAY_W-1:0]           day_stamp,
    output logic                                accepted,
    output logic [ppt_pkg::EV_W-1:0]            phase_event,
    output logic [ppt_pkg::MODE_W-1:0]          run_state,
    output logic [ppt_pkg::PHASE_W-1:0]         shown_phase,
    output logic [ppt_pkg::SEC_W-1:0]           seconds_left,
    output logic [ppt_pkg::SEC_W-1:0]           phase_total_seconds,
    output logic [ppt_pkg::PM_W-1:0]            progress_permille,
    output logic [ppt_pkg::STAT_W-1:0]          run_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          day_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          day_focus_minutes,
    output logic [ppt_pkg::STAT_W-1:0]          life_focus_count,
    output logic [ppt_pkg::STAT_W-1:0]          life_focus_minutes
);
    import ppt_pkg::*;

    // config
    logic [FOCUS_W-1:0]  focus_reg,  focus_next;
    logic [BRK_W-1:0]    short_reg,  short_next;
    logic [BRK_W-1:0]    long_reg,   long_next;
    logic [ROUNDS_W-1:0] per_long_reg, per_long_next;
    logic                auto_reg,   auto_next;

    // timer state
    mode_t               mode_reg,   mode_next;
    logic [PHASE_W-1:0]  resume_reg, resume_next;
    logic [SEC_W-1:0]    rem_reg,    rem_next;
    logic [ROUNDS_W-1:0] rounds_reg, rounds_next;
    logic [DAY_W-1:0]    day_reg,    day_next;
    logic [STAT_W-1:0]   run_cnt_reg,  run_cnt_next;
    logic [STAT_W-1:0]   day_cnt_reg,  day_cnt_next;
    logic [STAT_W-1:0]   day_min_reg,  day_min_next;
    logic [STAT_W-1:0]   life_cnt_reg, life_cnt_next;
    logic [STAT_W-1:0]   life_min_reg, life_min_next;

    // per-item result fields
    logic                acc_reg,  acc_next;
    logic [EV_W-1:0]     ev_reg,   ev_next;

    // divider and prep
    logic [PHASE_W-1:0]   shown_reg;
    logic [SEC_W-1:0]     total_reg;
    logic [SEC_W-1:0]     drem_reg;
    logic [PM_W-1:0]      quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    // output register
    logic                acc_out_reg;
    logic [EV_W-1:0]     ev_out_reg;
    logic [MODE_W-1:0]   mode_out_reg;
    logic [PHASE_W-1:0]  shown_out_reg;
    logic [SEC_W-1:0]    left_out_reg;
    logic [SEC_W-1:0]    total_out_reg;
    logic [PM_W-1:0]     pm_out_reg;
    logic [STAT_W-1:0]   run_out_reg, dcnt_out_reg, dmin_out_reg, lcnt_out_reg, lmin_out_reg;

    function automatic logic [SEC_W-1:0] phase_len(
        input logic [PHASE_W-1:0] ph,
        input logic [FOCUS_W-1:0] f,
        input logic [BRK_W-1:0]   s,
        input logic [BRK_W-1:0]   l
    );
        logic [SEC_W-1:0] len;
        case (ph)
            PHASE_W'(MODE_FOCUS): len = SEC_W'(f) * SEC_W'(SECS_PER_MIN);
            PHASE_W'(MODE_SHORT): len = SEC_W'(s) * SEC_W'(SECS_PER_MIN);
            PHASE_W'(MODE_LONG):  len = SEC_W'(l) * SEC_W'(SECS_PER_MIN);
            default:              len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(
        input logic [STAT_W-1:0]  a,
        input logic [FOCUS_W-1:0] b
    );
        logic [STAT_W:0] sum;
        sum = {1'b0, a} + (STAT_W + 1)'(b);
        return sum[STAT_W] ? {STAT_W{1'b1}} : sum[STAT_W-1:0];
    endfunction

    logic                running;
    logic                rem_gt;
    logic [TICK_W-1:0]   surplus;
    logic [ROUNDS_W-1:0] rounds_inc;
    mode_t               next_phase;
    logic [SEC_W-1:0]    next_len;

    always_comb
    begin
        focus_next    = focus_reg;
        short_next    = short_reg;
        long_next     = long_reg;
        per_long_next = per_long_reg;
        auto_next     = auto_reg;
        mode_next     = mode_reg;
        resume_next   = resume_reg;
        rem_next      = rem_reg;
        rounds_next   = rounds_reg;
        day_next      = day_reg;
        run_cnt_next  = run_cnt_reg;
        day_cnt_next  = day_cnt_reg;
        day_min_next  = day_min_reg;
        life_cnt_next = life_cnt_reg;
        life_min_next = life_min_reg;
        acc_next      = acc_reg;
        ev_next       = ev_reg;

        running    = (mode_reg == MODE_FOCUS) || (mode_reg == MODE_SHORT)
                     || (mode_reg == MODE_LONG);
        rem_gt     = TICK_W'(rem_reg) > tick_seconds;
        surplus    = tick_seconds - TICK_W'(rem_reg);
        rounds_inc = rounds_reg + ROUNDS_W'(1);
        if ((mode_reg == MODE_FOCUS) && (32'(rounds_inc) < 32'(per_long_reg)))
        begin
            next_phase = MODE_SHORT;
        end
        else if (mode_reg == MODE_FOCUS)
        begin
            next_phase = MODE_LONG;
        end
        else
        begin
            next_phase = MODE_FOCUS;
        end
        next_len = phase_len(next_phase[PHASE_W-1:0], focus_reg, short_reg, long_reg);

        // config writes, lengths and rounds only while idle
        if (cfg_we)
        begin
            if (cfg_index == CFG_AUTO)
            begin
                auto_next = cfg_data[0];
            end
            else if (mode_reg == MODE_IDLE)
            begin
                case (cfg_index)
                    CFG_FOCUS:
                    begin
                        if (cfg_data == '0)
                            focus_next = FOCUS_W'(1);
                        else if (32'(cfg_data) > MAX_PHASE_MINUTES)
                            focus_next = FOCUS_W'(MAX_PHASE_MINUTES);
                        else
                            focus_next = cfg_data[FOCUS_W-1:0];
                    end
                    CFG_SHORT:
                    begin
                        if (cfg_data[BRK_W-1:0] == '0)
                            short_next = BRK_W'(1);
                        else if (32'(cfg_data[BRK_W-1:0]) > BRK_HI)
                            short_next = BRK_W'(BRK_HI);
                        else
                            short_next = cfg_data[BRK_W-1:0];
                    end
                    CFG_LONG:
                    begin
                        if (cfg_data[BRK_W-1:0] == '0)
                            long_next = BRK_W'(1);
                        else if (32'(cfg_data[BRK_W-1:0]) > BRK_HI)
                            long_next = BRK_W'(BRK_HI);
                        else
                            long_next = cfg_data[BRK_W-1:0];
                    end
                    CFG_ROUNDS:
                    begin
                        if (cfg_data[ROUNDS_W-1:0] == '0)
                            per_long_next = ROUNDS_W'(1);
                        else if (32'(cfg_data[ROUNDS_W-1:0]) > ROUNDS_MAX)
                            per_long_next = ROUNDS_W'(ROUNDS_MAX);
                        else
                            per_long_next = cfg_data[ROUNDS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cmd.exec)
        begin
            acc_next = 1'b0;
            ev_next  = EV_NONE;
            case (opcode)
                OP_TICK:
                begin
                    if ((tick_seconds != '0) && running)
                    begin
                        if (rem_gt)
                        begin
                            rem_next = rem_reg - tick_seconds[SEC_W-1:0];
                        end
                        else
                        begin
                            if (mode_reg == MODE_FOCUS)
                            begin
                                run_cnt_next  = sat_add(run_cnt_reg, FOCUS_W'(1));
                                day_cnt_next  = sat_add(day_cnt_reg, FOCUS_W'(1));
                                day_min_next  = sat_add(day_min_reg, focus_reg);
                                life_cnt_next = sat_add(life_cnt_reg, FOCUS_W'(1));
                                life_min_next = sat_add(life_min_reg, focus_reg);
                                rounds_next   = (next_phase == MODE_LONG) ? '0 : rounds_inc;
                                ev_next       = EV_FOCUS;
                            end
                            else
                            begin
                                ev_next = EV_BREAK;
                            end
                            resume_next = PHASE_W'(MODE_IDLE);
                            if (!auto_reg)
                            begin
                                mode_next = MODE_IDLE;
                                rem_next  = '0;
                            end
                            else
                            begin
                                mode_next = next_phase;
                                // carry the surplus, clamp at zero
                                if (TICK_W'(next_len) > surplus)
                                    rem_next = next_len - surplus[SEC_W-1:0];
                                else
                                    rem_next = '0;
                            end
                        end
                    end
                end
                OP_START, OP_TOGGLE:
                begin
                    if ((opcode == OP_START && !running) || mode_reg == MODE_IDLE)
                    begin
                        mode_next   = MODE_FOCUS;
                        resume_next = PHASE_W'(MODE_IDLE);
                        rem_next    = phase_len(PHASE_W'(MODE_FOCUS), focus_reg,
                                                short_reg, long_reg);
                        acc_next    = 1'b1;
                    end
                    else if (opcode == OP_TOGGLE && running)
                    begin
                        resume_next = mode_reg[PHASE_W-1:0];
                        mode_next   = MODE_PAUSED;
                        acc_next    = 1'b1;
                    end
                    else if (opcode == OP_TOGGLE && mode_reg == MODE_PAUSED)
                    begin
                        // no stored phase resumes into focus
                        mode_next = (resume_reg != PHASE_W'(MODE_IDLE))
                                    ? mode_t'({1'b0, resume_reg}) : MODE_FOCUS;
                        acc_next  = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    mode_next   = MODE_IDLE;
                    resume_next = PHASE_W'(MODE_IDLE);
                    rem_next    = '0;
                    acc_next    = 1'b1;
                end
                OP_DAY:
                begin
                    if (day_stamp != '0)
                    begin
                        if (day_reg == '0)
                        begin
                            day_next = day_stamp;
                        end
                        else if (day_reg != day_stamp)
                        begin
                            day_next     = day_stamp;
                            day_cnt_next = '0;
                            day_min_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg    <= FOCUS_W'(25);
            short_reg    <= BRK_W'(5);
            long_reg     <= BRK_W'(15);
            per_long_reg <= ROUNDS_W'(4);
            auto_reg     <= 1'b1;
            mode_reg     <= MODE_IDLE;
            resume_reg   <= PHASE_W'(MODE_IDLE);
            rem_reg      <= '0;
            rounds_reg   <= '0;
            day_reg      <= '0;
            run_cnt_reg  <= '0;
            day_cnt_reg  <= '0;
            day_min_reg  <= '0;
            life_cnt_reg <= '0;
            life_min_reg <= '0;
        end
        else
        begin
            focus_reg    <= focus_next;
            short_reg    <= short_next;
            long_reg     <= long_next;
            per_long_reg <= per_long_next;
            auto_reg     <= auto_next;
            mode_reg     <= mode_next;
            resume_reg   <= resume_next;
            rem_reg      <= rem_next;
            rounds_reg   <= rounds_next;
            day_reg      <= day_next;
            run_cnt_reg  <= run_cnt_next;
            day_cnt_reg  <= day_cnt_next;
            day_min_reg  <= day_min_next;
            life_cnt_reg <= life_cnt_next;
            life_min_reg <= life_min_next;
        end
    end

    // prep: shown phase, total, scaled elapsed time
    logic [PHASE_W-1:0] shown_c;
    logic [SEC_W-1:0]   total_c;
    logic [SEC_W-1:0]   clamp_c;
    logic [PROD_W-1:0]  prod_c;

    always_comb
    begin
        shown_c = (mode_reg == MODE_PAUSED) ? resume_reg : mode_reg[PHASE_W-1:0];
        total_c = phase_len(shown_c, focus_reg, short_reg, long_reg);
        clamp_c = (rem_reg > total_c) ? total_c : rem_reg;
        prod_c  = PROD_W'(total_c - clamp_c) * PROD_W'(PERMILLE);
    end

    // restoring divider, one quotient bit a step; the upper part of the
    // product is already below the divisor since the quotient fits PM_W bits
    logic [SEC_W:0]   dshift;
    logic             dge;

    always_comb
    begin
        dshift        = {drem_reg, quo_reg[PM_W-1]};
        dge           = dshift >= {1'b0, total_reg};
        stat.div_last = (dcnt_reg == DIV_CNT_W'(PM_W - 1));
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ev_reg  <= ev_next;
        if (cmd.prep)
        begin
            shown_reg <= shown_c;
            total_reg <= total_c;
            drem_reg  <= prod_c[PROD_W-1:PM_W];
            quo_reg   <= prod_c[PM_W-1:0];
            dcnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            drem_reg <= dge ? SEC_W'(dshift - {1'b0, total_reg}) : dshift[SEC_W-1:0];
            quo_reg  <= {quo_reg[PM_W-2:0], dge};
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.load)
        begin
            acc_out_reg   <= acc_reg;
            ev_out_reg    <= ev_reg;
            mode_out_reg  <= mode_reg;
            shown_out_reg <= shown_reg;
            left_out_reg  <= rem_reg;
            total_out_reg <= total_reg;
            pm_out_reg    <= (total_reg == '0) ? '0 : quo_reg;
            run_out_reg   <= run_cnt_reg;
            dcnt_out_reg  <= day_cnt_reg;
            dmin_out_reg  <= day_min_reg;
            lcnt_out_reg  <= life_cnt_reg;
            lmin_out_reg  <= life_min_reg;
        end
    end

    assign accepted            = acc_out_reg;
    assign phase_event         = ev_out_reg;
    assign run_state           = mode_out_reg;
    assign shown_phase         = shown_out_reg;
    assign seconds_left        = left_out_reg;
    assign phase_total_seconds = total_out_reg;
    assign progress_permille   = pm_out_reg;
    assign run_focus_count     = run_out_reg;
    assign day_focus_count     = dcnt_out_reg;
    assign day_focus_minutes   = dmin_out_reg;
    assign life_focus_count    = lcnt_out_reg;
    assign life_focus_minutes  = lmin_out_reg;

endmodule

/* rtl/ppt_checker.sv */
// port-level checks of the pomodoro phase timer, bound to the top level
`include "pomodoro_phase_timer_top_defines.svh"

module ppt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ppt_pkg::MODE_W-1:0]   run_state,
    input logic [ppt_pkg::SEC_W-1:0]    seconds_left,
    input logic [ppt_pkg::SEC_W-1:0]    phase_total_seconds,
    input logic [ppt_pkg::PM_W-1:0]     progress_permille
);
    import ppt_pkg::*;

    // a stalled result stays offered
    `PPT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

    // one item in flight: the input closes right after an accept
    `PPT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // an idle result shows no phase, no time and no progress
    `PPT_ASSERT_IMP(a_idle_result, out_valid && run_state == MODE_IDLE,
        phase_total_seconds == '0 && seconds_left == '0 && progress_permille == '0)

    // remaining time never exceeds the phase and progress stays in range
    `PPT_ASSERT_IMP(a_result_bounds, out_valid,
        seconds_left <= phase_total_seconds && 32'(progress_permille) <= PERMILLE)

endmodule

bind pomodoro_phase_timer_top ppt_checker u_ppt_checker (.*);

/* tb/pomodoro_phase_timer_top_tb.sv */
// self-checking testbench of the pomodoro phase timer: directed table, then random command phases
module pomodoro_phase_timer_top_tb;

    import ppt_pkg::*;

    // spare codes that the block must ignore
    localparam logic [OP_W-1:0]      OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // cycles left to the block after the last result before config or the end
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 600;
    localparam int REPORT_LIMIT  = 10;

    // one result item as the block reports it
    typedef struct {
        logic                 acc;
        logic [EV_W-1:0]      ev;
        logic [MODE_W-1:0]    state;
        logic [PHASE_W-1:0]   shown;
        logic [SEC_W-1:0]     left;
        logic [SEC_W-1:0]     total;
        logic [PM_W-1:0]      pm;
        logic [STAT_W-1:0]    run_cnt;
        logic [STAT_W-1:0]    day_cnt;
        logic [STAT_W-1:0]    day_min;
        logic [STAT_W-1:0]    life_cnt;
        logic [STAT_W-1:0]    life_min;
    } timer_status_t;

    // one line of the directed table: a command item or a register write
    typedef struct {
        bit                   is_cfg;
        logic [OP_W-1:0]      code;
        logic [TICK_W-1:0]    secs;
        logic [DAY_W-1:0]     word;
        bit                   typed;
        timer_status_t        res;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode = '0;
    logic [TICK_W-1:0]        tick_seconds = '0;
    logic [DAY_W-1:0]         day_stamp = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     accepted;
    logic [EV_W-1:0]          phase_event;
    logic [MODE_W-1:0]        run_state;
    logic [PHASE_W-1:0]       shown_phase;
    logic [SEC_W-1:0]         seconds_left;
    logic [SEC_W-1:0]         phase_total_seconds;
    logic [PM_W-1:0]          progress_permille;
    logic [STAT_W-1:0]        run_focus_count;
    logic [STAT_W-1:0]        day_focus_count;
    logic [STAT_W-1:0]        day_focus_minutes;
    logic [STAT_W-1:0]        life_focus_count;
    logic [STAT_W-1:0]        life_focus_minutes;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    pomodoro_phase_timer_top DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (opcode),
        .tick_seconds        (tick_seconds),
        .day_stamp           (day_stamp),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .accepted            (accepted),
        .phase_event         (phase_event),
        .run_state           (run_state),
        .shown_phase         (shown_phase),
        .seconds_left        (seconds_left),
        .phase_total_seconds (phase_total_seconds),
        .progress_permille   (progress_permille),
        .run_focus_count     (run_focus_count),
        .day_focus_count     (day_focus_count),
        .day_focus_minutes   (day_focus_minutes),
        .life_focus_count    (life_focus_count),
        .life_focus_minutes  (life_focus_minutes),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // timer predictor: settings, phase state and statistics counters
    // ------------------------------------------------------------------
    int unsigned          set_focus  = 25;
    int unsigned          set_short  = 5;
    int unsigned          set_long   = 15;
    int unsigned          set_rounds = 4;
    bit                   set_auto   = 1'b1;

    mode_t                tmr_mode   = MODE_IDLE;
    mode_t                tmr_resume = MODE_IDLE;
    logic [SEC_W-1:0]     tmr_left   = '0;
    int unsigned          tmr_rounds = 0;
    logic [DAY_W-1:0]     tmr_day    = '0;
    logic [STAT_W-1:0]    cnt_run    = '0;
    logic [STAT_W-1:0]    cnt_day    = '0;
    logic [STAT_W-1:0]    min_day    = '0;
    logic [STAT_W-1:0]    cnt_life   = '0;
    logic [STAT_W-1:0]    min_life   = '0;

    // expected results in order of acceptance
    timer_status_t        due_status[$];
    script_row_t          script[$];
    int unsigned          mismatch_cnt = 0;

    // both sides stop idling while this is set
    bit                   calm = 1'b0;
    // in_valid is currently driven high
    bit                   feeding = 1'b0;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(logic [STAT_W-1:0] a, int unsigned b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + b;
        return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

    function automatic int unsigned phase_seconds(mode_t ph);
        case (ph)
            MODE_FOCUS: return set_focus * SECS_PER_MIN;
            MODE_SHORT: return set_short * SECS_PER_MIN;
            MODE_LONG:  return set_long * SECS_PER_MIN;
            default:    return 0;
        endcase
    endfunction

    function automatic bit timer_running();
        return tmr_mode == MODE_FOCUS || tmr_mode == MODE_SHORT || tmr_mode == MODE_LONG;
    endfunction

    function automatic bit start_focus();
        if (timer_running())
            return 1'b0;
        tmr_mode   = MODE_FOCUS;
        tmr_resume = MODE_IDLE;
        tmr_left   = SEC_W'(phase_seconds(MODE_FOCUS));
        return 1'b1;
    endfunction

    // register write; lengths and rounds only take while the timer is idle
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_AUTO)
            set_auto = data[0];
        else if (tmr_mode == MODE_IDLE)
        begin
            case (idx)
                CFG_FOCUS:  set_focus  = clamp_to(data, 1, MAX_PHASE_MINUTES);
                CFG_SHORT:  set_short  = clamp_to(data[BRK_W-1:0], 1, BRK_HI);
                CFG_LONG:   set_long   = clamp_to(data[BRK_W-1:0], 1, BRK_HI);
                CFG_ROUNDS: set_rounds = clamp_to(data[ROUNDS_W-1:0], 1, ROUNDS_MAX);
                default:    ;
            endcase
        end
    endfunction

    // one command item: new timer state and the status it reports
    function automatic timer_status_t advance_timer(logic [OP_W-1:0] op,
                                                    logic [TICK_W-1:0] secs,
                                                    logic [DAY_W-1:0] day);
        timer_status_t r;
        int unsigned   surplus;
        int unsigned   plen;
        int unsigned   total;
        int unsigned   clipped;
        mode_t         nxt;
        mode_t         shown_ph;
        r = '{default: '0};
        case (op)
            OP_TICK:
                if (secs != 0 && timer_running())
                begin
                    if (tmr_left > secs)
                        tmr_left = tmr_left - secs;
                    else
                    begin
                        // phase end, carry the surplus into the next phase
                        surplus = secs - tmr_left;
                        if (tmr_mode == MODE_FOCUS)
                        begin
                            cnt_run  = sat_add(cnt_run, 1);
                            cnt_day  = sat_add(cnt_day, 1);
                            min_day  = sat_add(min_day, set_focus);
                            cnt_life = sat_add(cnt_life, 1);
                            min_life = sat_add(min_life, set_focus);
                            r.ev = EV_FOCUS;
                            tmr_rounds++;
                            if (tmr_rounds >= set_rounds)
                            begin
                                tmr_rounds = 0;
                                nxt = MODE_LONG;
                            end
                            else
                                nxt = MODE_SHORT;
                        end
                        else
                        begin
                            r.ev = EV_BREAK;
                            nxt = MODE_FOCUS;
                        end
                        tmr_resume = MODE_IDLE;
                        if (!set_auto)
                        begin
                            tmr_mode = MODE_IDLE;
                            tmr_left = '0;
                        end
                        else
                        begin
                            tmr_mode = nxt;
                            plen = phase_seconds(nxt);
                            tmr_left = (surplus >= plen) ? '0 : SEC_W'(plen - surplus);
                        end
                    end
                end
            OP_START:
                r.acc = start_focus();
            OP_TOGGLE:
                if (tmr_mode == MODE_IDLE)
                    r.acc = start_focus();
                else if (timer_running())
                begin
                    tmr_resume = tmr_mode;
                    tmr_mode = MODE_PAUSED;
                    r.acc = 1'b1;
                end
                else
                begin
                    // resume, into focus when no phase was kept
                    if (tmr_resume == MODE_FOCUS || tmr_resume == MODE_SHORT
                        || tmr_resume == MODE_LONG)
                        tmr_mode = tmr_resume;
                    else
                        tmr_mode = MODE_FOCUS;
                    r.acc = 1'b1;
                end
            OP_STOP:
            begin
                tmr_mode = MODE_IDLE;
                tmr_resume = MODE_IDLE;
                tmr_left = '0;
                r.acc = 1'b1;
            end
            OP_DAY:
                if (day != 0)
                begin
                    if (tmr_day == 0)
                        tmr_day = day;
                    else if (tmr_day != day)
                    begin
                        tmr_day = day;
                        cnt_day = '0;
                        min_day = '0;
                    end
                end
            default: ;
        endcase

        shown_ph = (tmr_mode == MODE_PAUSED) ? tmr_resume : tmr_mode;
        total = phase_seconds(shown_ph);
        r.state = tmr_mode;
        r.shown = shown_ph[PHASE_W-1:0];
        r.left  = tmr_left;
        r.total = SEC_W'(total);
        if (total > 0)
        begin
            clipped = (tmr_left > total) ? total : tmr_left;
            r.pm = PM_W'(((total - clipped) * PERMILLE) / total);
        end
        r.run_cnt  = cnt_run;
        r.day_cnt  = cnt_day;
        r.day_min  = min_day;
        r.life_cnt = cnt_life;
        r.life_min = min_life;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // idle cycles before the next item: mostly none, a few long
    function automatic int unsigned idle_span();
        int unsigned pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // presents one item, waits for the accept and records what it must yield;
    // typed rows replace the timer fields of the prediction with the table values
    task automatic send_cmd(logic [OP_W-1:0] op, logic [TICK_W-1:0] secs,
                            logic [DAY_W-1:0] day, bit typed, timer_status_t fixed);
        int unsigned   gap;
        timer_status_t want;
        gap = idle_span();
        if (gap > 0)
        begin
            if (feeding)
                in_valid <= 1'b0;
            feeding = 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= op;
        tick_seconds <= secs;
        day_stamp    <= day;
        in_valid     <= 1'b1;
        feeding = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge
        want = advance_timer(op, secs, day);
        if (typed)
        begin
            want.acc   = fixed.acc;
            want.ev    = fixed.ev;
            want.state = fixed.state;
            want.shown = fixed.shown;
            want.left  = fixed.left;
            want.total = fixed.total;
            want.pm    = fixed.pm;
        end
        due_status.push_back(want);
    endtask

    // input idle, every result in, block left to settle
    task automatic quiesce();
        if (feeding)
            in_valid <= 1'b0;
        feeding = 1'b0;
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_setting(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    task automatic put_cmd(logic [OP_W-1:0] op, logic [TICK_W-1:0] secs, logic [DAY_W-1:0] day);
        script_row_t row;
        row = '{default: '0};
        row.code = op;
        row.secs = secs;
        row.word = day;
        script.push_back(row);
    endtask

    task automatic put_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.code = idx;
        row.word = data;
        script.push_back(row);
    endtask

    task automatic put_typed(logic [OP_W-1:0] op, logic [TICK_W-1:0] secs, logic [DAY_W-1:0] day,
                             logic acc, logic [EV_W-1:0] ev, mode_t st, mode_t sh,
                             int unsigned left, int unsigned total, int unsigned pm);
        script_row_t row;
        row = '{default: '0};
        row.code      = op;
        row.secs      = secs;
        row.word      = day;
        row.typed     = 1'b1;
        row.res.acc   = acc;
        row.res.ev    = ev;
        row.res.state = st;
        row.res.shown = sh[PHASE_W-1:0];
        row.res.left  = SEC_W'(left);
        row.res.total = SEC_W'(total);
        row.res.pm    = PM_W'(pm);
        script.push_back(row);
    endtask

    task automatic build_script();
        // idle after reset: nothing moves
        put_typed(OP_TICK, 16'd0, 32'd0, 0, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        put_typed(OP_TICK, 16'hffff, 32'd0, 0, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        put_typed(OP_SPARE_LO, 16'hffff, 32'hffff_ffff, 0, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        // zero day stamp, then the first real one
        put_typed(OP_DAY, 16'd0, 32'd0, 0, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        put_typed(OP_DAY, 16'd0, 32'hffff_ffff, 0, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        // toggle from idle starts focus, start while running is refused
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_FOCUS, MODE_FOCUS, 1500, 1500, 0);
        put_typed(OP_START, 16'd0, 32'd0, 0, EV_NONE, MODE_FOCUS, MODE_FOCUS, 1500, 1500, 0);
        put_typed(OP_TICK, 16'd0, 32'd0, 0, EV_NONE, MODE_FOCUS, MODE_FOCUS, 1500, 1500, 0);
        put_typed(OP_TICK, 16'd750, 32'd0, 0, EV_NONE, MODE_FOCUS, MODE_FOCUS, 750, 1500, 500);
        // pause, tick while paused, start from pause gives a fresh focus
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_PAUSED, MODE_FOCUS, 750, 1500, 500);
        put_typed(OP_TICK, 16'd500, 32'd0, 0, EV_NONE, MODE_PAUSED, MODE_FOCUS, 750, 1500, 500);
        put_typed(OP_START, 16'd0, 32'd0, 1, EV_NONE, MODE_FOCUS, MODE_FOCUS, 1500, 1500, 0);
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_PAUSED, MODE_FOCUS, 1500, 1500, 0);
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_FOCUS, MODE_FOCUS, 1500, 1500, 0);
        // largest tick: surplus clamps the break to zero, then one second ends it
        put_typed(OP_TICK, 16'hffff, 32'd0, 0, EV_FOCUS, MODE_SHORT, MODE_SHORT, 0, 300, 1000);
        put_typed(OP_TICK, 16'd1, 32'd0, 0, EV_BREAK, MODE_FOCUS, MODE_FOCUS, 1499, 1500, 0);
        // same day keeps the daily counters, a new day clears them
        put_cmd(OP_DAY, 16'd0, 32'hffff_ffff);
        put_cmd(OP_DAY, 16'hffff, 32'd1);
        put_typed(OP_STOP, 16'd0, 32'd0, 1, EV_NONE, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        // out-of-range writes clamp, spare index ignored, auto-next off
        put_cfg(CFG_FOCUS, 7'h7f);
        put_cfg(CFG_SHORT, 7'h3f);
        put_cfg(CFG_LONG, 7'h40);
        put_cfg(CFG_ROUNDS, 7'h1f);
        put_cfg(CFG_SPARE_LO, 7'h7f);
        put_cfg(CFG_AUTO, 7'h7e);
        put_typed(OP_START, 16'd0, 32'd0, 1, EV_NONE, MODE_FOCUS, MODE_FOCUS, 7200, 7200, 0);
        put_typed(OP_TICK, 16'd7200, 32'd0, 0, EV_FOCUS, MODE_IDLE, MODE_IDLE, 0, 0, 0);
        // shortest focus and long break, long break after every focus
        put_cfg(CFG_FOCUS, 7'h00);
        put_cfg(CFG_ROUNDS, 7'h01);
        put_cfg(CFG_AUTO, 7'h01);
        put_typed(OP_START, 16'd0, 32'd0, 1, EV_NONE, MODE_FOCUS, MODE_FOCUS, 60, 60, 0);
        put_typed(OP_TICK, 16'd60, 32'd0, 0, EV_FOCUS, MODE_LONG, MODE_LONG, 60, 60, 0);
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_PAUSED, MODE_LONG, 60, 60, 0);
        // length write while paused must not take
        put_cfg(CFG_FOCUS, 7'd50);
        put_typed(OP_TOGGLE, 16'd0, 32'd0, 1, EV_NONE, MODE_LONG, MODE_LONG, 60, 60, 0);
        put_typed(OP_TICK, 16'd30, 32'd0, 0, EV_NONE, MODE_LONG, MODE_LONG, 30, 60, 500);
    endtask

    // ------------------------------------------------------------------
    // random commands, steered by the predicted timer state
    // ------------------------------------------------------------------
    function automatic logic [CFG_DATA_W-1:0] pick_setting(logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] field_max;
        logic [CFG_DATA_W-1:0] legal_max;
        logic [CFG_DATA_W-1:0] brisk;
        logic [CFG_DATA_W-1:0] noise;
        int unsigned           pick;
        noise = CFG_DATA_W'($urandom);
        pick  = $urandom_range(0, 99);
        case (idx)
            CFG_FOCUS:
            begin
                field_max = '1;
                legal_max = CFG_DATA_W'(MAX_PHASE_MINUTES);
                brisk     = CFG_DATA_W'($urandom_range(1, 4));
            end
            CFG_SHORT, CFG_LONG:
            begin
                field_max = CFG_DATA_W'((1 << BRK_W) - 1);
                legal_max = CFG_DATA_W'(BRK_HI);
                brisk     = CFG_DATA_W'($urandom_range(1, 3));
            end
            CFG_ROUNDS:
            begin
                field_max = CFG_DATA_W'((1 << ROUNDS_W) - 1);
                legal_max = CFG_DATA_W'(ROUNDS_MAX);
                brisk     = CFG_DATA_W'($urandom_range(1, 5));
            end
            CFG_AUTO:
                return {noise[CFG_DATA_W-1:1], ($urandom_range(0, 99) < 70)};
            default:
                return noise;
        endcase
        if (pick < 10)
            return '0;
        if (pick < 20)
            return field_max;
        if (pick < 30)
            return legal_max;
        if (pick < 38)
            return CFG_DATA_W'(1);
        if (pick < 48)
            return noise;
        return brisk;
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '0;
        if (pick < 45)
            return TICK_W'($urandom_range(1, 90));
        if (pick < 68)
            return TICK_W'($urandom_range(1, tmr_left + 5));
        // exactly onto the phase end
        if (pick < 80)
            return TICK_W'(tmr_left);
        if (pick < 90)
            return TICK_W'($urandom_range(60, 2000));
        return TICK_W'($urandom);
    endfunction

    function automatic logic [DAY_W-1:0] pick_day();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 40)
            return tmr_day;
        if (pick < 80)
            return DAY_W'($urandom_range(1, 5));
        return DAY_W'($urandom);
    endfunction

    task automatic send_random();
        int unsigned       pick;
        logic [OP_W-1:0]   op;
        logic [TICK_W-1:0] secs;
        logic [DAY_W-1:0]  day;
        timer_status_t     blank;
        blank = '{default: '0};
        pick  = $urandom_range(0, 99);
        if (tmr_mode == MODE_IDLE)
            op = (pick < 40) ? OP_START : (pick < 70) ? OP_TOGGLE : (pick < 80) ? OP_TICK
               : (pick < 85) ? OP_STOP : (pick < 95) ? OP_DAY
               : OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (tmr_mode == MODE_PAUSED)
            op = (pick < 50) ? OP_TOGGLE : (pick < 60) ? OP_START : (pick < 75) ? OP_TICK
               : (pick < 80) ? OP_STOP : (pick < 90) ? OP_DAY
               : OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            op = (pick < 74) ? OP_TICK : (pick < 82) ? OP_TOGGLE : (pick < 85) ? OP_START
               : (pick < 88) ? OP_STOP : (pick < 96) ? OP_DAY
               : OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        // fields the command does not use carry noise
        secs = (op == OP_TICK) ? pick_tick() : TICK_W'($urandom);
        day  = (op == OP_DAY) ? pick_day() : DAY_W'($urandom);
        send_cmd(op, secs, day, 1'b0, blank);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int unsigned   issued;
        int unsigned   phase_items;
        timer_status_t blank;
        blank  = '{default: '0};
        issued = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_script();
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                quiesce();
                cfg_write(script[i].code, script[i].word[CFG_DATA_W-1:0]);
            end
            else
                send_cmd(script[i].code, script[i].secs, script[i].word,
                         script[i].typed, script[i].res);
        end

        // random phases, each opened by a drained pipe and fresh settings
        while (issued < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 60)
            begin
                send_cmd(OP_STOP, TICK_W'($urandom), DAY_W'($urandom), 1'b0, blank);
                issued++;
            end
            quiesce();
            for (int idx = CFG_FOCUS; idx <= CFG_AUTO; idx++)
                if ($urandom_range(0, 99) < 75)
                    cfg_write(CFG_IDX_W'(idx), pick_setting(CFG_IDX_W'(idx)));
            if ($urandom_range(0, 99) < 15)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          CFG_DATA_W'($urandom));
            calm = ($urandom_range(0, 99) < 20);
            phase_items = $urandom_range(30, 90);
            repeat (phase_items)
            begin
                send_random();
                issued++;
            end
        end

        calm = 1'b0;
        quiesce();
        if (mismatch_cnt == 0 && due_status.size() == 0)
            $display("** pomodoro_phase_timer_top: PASSED **");
        else
            $display("** pomodoro_phase_timer_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side: random stall, compare against the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    int unsigned stall_run = 0;

    always @(posedge clk)
    begin : result_side
        timer_status_t want;
        int unsigned   pick;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_status.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("result item with nothing expected");
            end
            else
            begin
                want = due_status.pop_front();
                compare_field("accepted", want.acc, accepted);
                compare_field("phase_event", want.ev, phase_event);
                compare_field("run_state", want.state, run_state);
                compare_field("shown_phase", want.shown, shown_phase);
                compare_field("seconds_left", want.left, seconds_left);
                compare_field("phase_total_seconds", want.total, phase_total_seconds);
                compare_field("progress_permille", want.pm, progress_permille);
                compare_field("run_focus_count", want.run_cnt, run_focus_count);
                compare_field("day_focus_count", want.day_cnt, day_focus_count);
                compare_field("day_focus_minutes", want.day_min, day_focus_minutes);
                compare_field("life_focus_count", want.life_cnt, life_focus_count);
                compare_field("life_focus_minutes", want.life_min, life_focus_minutes);
            end
        end
        // stall pattern: mostly open, short holds, now and then a long one
        if (stall_run > 0)
            stall_run = stall_run - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                stall_run = (pick < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("** pomodoro_phase_timer_top: FAILED **");
        $finish;
    end

endmodule

/* pomodoro_phase_timer_top.f */
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_ctrl.sv
rtl/ppt_dp.sv
rtl/pomodoro_phase_timer_top.sv
rtl/ppt_checker.sv
tb/pomodoro_phase_timer_top_tb.sv
